[rtl/core/ccv_pkg.sv]
`timescale 1ns / 1ps

package ccv_pkg;

   localparam int LVL_W = 10;
   localparam int PIX_W = 8;
   localparam int FUNC_W = 2;

   typedef logic [LVL_W-1:0] level_type;
   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FUNC_TO_CMYK = 2'd0;
   localparam func_type FUNC_TO_RGB = 2'd1;
   localparam func_type FUNC_ROUND_TRIP = 2'd2;

   localparam level_type LEVELS_RESET = 10'd100;
   localparam pixel_type FULL_SCALE = 8'd255;

   typedef struct packed {
      func_type func;
      pixel_type red_in;
      pixel_type green_in;
      pixel_type blue_in;
      level_type cyan_in;
      level_type magenta_in;
      level_type yellow_in;
      level_type black_in;
   } req_word_type;

   typedef struct packed {
      level_type cyan_out;
      level_type magenta_out;
      level_type yellow_out;
      level_type black_out;
      pixel_type red_out;
      pixel_type green_out;
      pixel_type blue_out;
   } rsp_word_type;

endpackage

[rtl/core/ccv_req_if.sv]
`timescale 1ns / 1ps

interface ccv_req_if;
   logic valid;
   logic ready;
   ccv_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

[rtl/core/ccv_rsp_if.sv]
`timescale 1ns / 1ps

interface ccv_rsp_if;
   logic valid;
   logic ready;
   ccv_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

[rtl/core/rgb_cmyk_color_convert.sv]
`timescale 1ns / 1ps

// Per-pixel RGB/CMYK colour converter.
// req_chan carries one pixel per word with a function code: RGB to CMYK,
// CMYK to RGB, or the round trip through both. rsp_chan returns exactly one
// word per request; fields that the function does not produce are zero.
// csr_write_enable/csr_write_data set the CMYK full-scale value (levels);
// write it only while no pixel is in flight. A value of zero acts as one.
// The pixel passes two input stages, a ten-stage divider for the CMY
// quotients, three stages for the selection and products, an eight-stage
// divider for the RGB quotients and the output register. Throughput is
// one pixel per clock while the receiver does not stall rsp_chan; every
// stage is registered.
// Reset empties the pipeline and sets levels to 100.
// When the receiver holds rsp_chan.ready low with a word waiting, the whole
// pipeline freezes and req_chan.ready drops; nothing is lost or repeated.
module rgb_cmyk_color_convert (
   input  logic clock,
   input  logic reset,
   ccv_req_if.sink req_chan,
   ccv_rsp_if.source rsp_chan,
   input  logic csr_write_enable,
   input  ccv_pkg::level_type csr_write_data
);

   localparam int PROD_W = ccv_pkg::PIX_W + ccv_pkg::LVL_W;
   localparam int SQ_W = 2 * ccv_pkg::LVL_W;
   localparam int NUM_W = SQ_W + ccv_pkg::PIX_W;
   localparam int SIDE_A_W = ccv_pkg::FUNC_W + 1 + PROD_W + 4 * ccv_pkg::LVL_W;
   localparam int SIDE_B_W = ccv_pkg::FUNC_W + 4 * ccv_pkg::LVL_W;
   localparam int RECIP_W = 19;
   localparam int K_PROD_W = PROD_W + RECIP_W;
   localparam int K_SHIFT = 26;
   localparam logic [RECIP_W-1:0] K_RECIP = 19'd263173;

   ccv_pkg::level_type levels_ff;
   ccv_pkg::level_type lev;
   logic advance;

   // Stage 1: maximum and saturation.
   logic s1_valid_ff;
   ccv_pkg::func_type s1_func_ff;
   ccv_pkg::pixel_type [2:0] s1_rgb_ff;
   ccv_pkg::pixel_type s1_mx_ff, s1_mx_in;
   ccv_pkg::level_type [3:0] s1_cmyk_ff, s1_cmyk_in;

   // Stage 2: numerators of the forward division.
   logic s2_valid_ff;
   logic [2:0][PROD_W-1:0] s2_num_ff, s2_num_in;
   logic [PROD_W-1:0] s2_knum_in;
   ccv_pkg::pixel_type [2:0] s2_den_ff;
   logic [SIDE_A_W-1:0] s2_side_ff;

   logic da_valid;
   ccv_pkg::level_type [2:0] da_quo;
   logic [SIDE_A_W-1:0] da_side;

   logic s3_valid_ff;
   ccv_pkg::func_type s3_func_ff;
   ccv_pkg::level_type [3:0] s3_cmyk_ff, s3_cmyk_in;

   logic m1_valid_ff;
   ccv_pkg::func_type m1_func_ff;
   ccv_pkg::level_type [3:0] m1_cmyk_ff;
   logic [2:0][SQ_W-1:0] m1_prod_ff, m1_prod_in;
   logic [SQ_W-1:0] m1_sq_ff;

   logic m2_valid_ff;
   logic [2:0][NUM_W-1:0] m2_num_ff, m2_num_in;
   logic [2:0][SQ_W-1:0] m2_den_ff;
   logic [SIDE_B_W-1:0] m2_side_ff;

   logic db_valid;
   ccv_pkg::pixel_type [2:0] db_quo;
   logic [SIDE_B_W-1:0] db_side;

   logic out_valid_ff;
   ccv_pkg::rsp_word_type out_word_ff, out_word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= ccv_pkg::LEVELS_RESET;
      end else if (csr_write_enable) begin
         levels_ff <= csr_write_data;
      end
   end

   assign lev = (levels_ff == '0) ? ccv_pkg::level_type'(1) : levels_ff;
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      ccv_pkg::level_type raw [4];
      s1_mx_in = req_chan.word.red_in;
      if (req_chan.word.green_in > s1_mx_in) begin
         s1_mx_in = req_chan.word.green_in;
      end
      if (req_chan.word.blue_in > s1_mx_in) begin
         s1_mx_in = req_chan.word.blue_in;
      end
      raw[0] = req_chan.word.cyan_in;
      raw[1] = req_chan.word.magenta_in;
      raw[2] = req_chan.word.yellow_in;
      raw[3] = req_chan.word.black_in;
      for (int i = 0; i < 4; i++) begin
         s1_cmyk_in[i] = (raw[i] > lev) ? lev : raw[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_num_in[i] = PROD_W'(s1_mx_ff - s1_rgb_ff[i]) * PROD_W'(lev);
      end
      s2_knum_in = PROD_W'(ccv_pkg::FULL_SCALE - s1_mx_ff) * PROD_W'(lev);
   end

   // A black pixel divides by zero; its chroma quotients are dropped below.
   // The black level divides by the constant 255 through a reciprocal
   // multiplication, which is exact for every numerator that can occur.
   always_comb begin
      ccv_pkg::func_type fn;
      logic black;
      logic [PROD_W-1:0] knum;
      logic [K_PROD_W-1:0] kprod;
      ccv_pkg::level_type [3:0] sat_cmyk;
      {fn, black, knum, sat_cmyk} = da_side;
      kprod = K_PROD_W'(knum) * K_PROD_W'(K_RECIP);
      if (fn == ccv_pkg::FUNC_TO_RGB) begin
         s3_cmyk_in = sat_cmyk;
      end else begin
         for (int i = 0; i < 3; i++) begin
            s3_cmyk_in[i] = black ? '0 : da_quo[i];
         end
         s3_cmyk_in[3] = ccv_pkg::level_type'(kprod >> K_SHIFT);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1_prod_in[i] = SQ_W'(lev - s3_cmyk_ff[i]) * SQ_W'(lev - s3_cmyk_ff[3]);
         m2_num_in[i] = {m1_prod_ff[i], ccv_pkg::PIX_W'(0)} - NUM_W'(m1_prod_ff[i]);
      end
   end

   always_comb begin
      ccv_pkg::func_type fn;
      ccv_pkg::level_type [3:0] cmyk;
      logic has_cmyk;
      logic has_rgb;
      {fn, cmyk} = db_side;
      has_cmyk = (fn == ccv_pkg::FUNC_TO_CMYK) || (fn == ccv_pkg::FUNC_ROUND_TRIP);
      has_rgb = (fn == ccv_pkg::FUNC_TO_RGB) || (fn == ccv_pkg::FUNC_ROUND_TRIP);
      out_word_in.cyan_out = has_cmyk ? cmyk[0] : '0;
      out_word_in.magenta_out = has_cmyk ? cmyk[1] : '0;
      out_word_in.yellow_out = has_cmyk ? cmyk[2] : '0;
      out_word_in.black_out = has_cmyk ? cmyk[3] : '0;
      out_word_in.red_out = has_rgb ? db_quo[0] : '0;
      out_word_in.green_out = has_rgb ? db_quo[1] : '0;
      out_word_in.blue_out = has_rgb ? db_quo[2] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= da_valid;
         m1_valid_ff <= s3_valid_ff;
         m2_valid_ff <= m1_valid_ff;
         out_valid_ff <= db_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff <= req_chan.word.func;
         s1_rgb_ff <= {req_chan.word.blue_in, req_chan.word.green_in,
                       req_chan.word.red_in};
         s1_mx_ff <= s1_mx_in;
         s1_cmyk_ff <= s1_cmyk_in;

         s2_num_ff <= s2_num_in;
         s2_den_ff <= {s1_mx_ff, s1_mx_ff, s1_mx_ff};
         s2_side_ff <= {s1_func_ff, (s1_mx_ff == '0), s2_knum_in, s1_cmyk_ff};

         s3_func_ff <= da_side[SIDE_A_W-1 -: ccv_pkg::FUNC_W];
         s3_cmyk_ff <= s3_cmyk_in;

         m1_func_ff <= s3_func_ff;
         m1_cmyk_ff <= s3_cmyk_ff;
         m1_prod_ff <= m1_prod_in;
         m1_sq_ff <= SQ_W'(lev) * SQ_W'(lev);

         m2_num_ff <= m2_num_in;
         m2_den_ff <= {m1_sq_ff, m1_sq_ff, m1_sq_ff};
         m2_side_ff <= {m1_func_ff, m1_cmyk_ff};

         out_word_ff <= out_word_in;
      end
   end

   ccv_div #(
      .LANES(3),
      .NW(PROD_W),
      .DW(ccv_pkg::PIX_W),
      .QW(ccv_pkg::LVL_W),
      .SW(SIDE_A_W)
   ) u_div_cmyk (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(s2_valid_ff),
      .num(s2_num_ff),
      .den(s2_den_ff),
      .side_in(s2_side_ff),
      .out_valid(da_valid),
      .quo(da_quo),
      .side_out(da_side)
   );

   ccv_div #(
      .LANES(3),
      .NW(NUM_W),
      .DW(SQ_W),
      .QW(ccv_pkg::PIX_W),
      .SW(SIDE_B_W)
   ) u_div_rgb (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(m2_valid_ff),
      .num(m2_num_ff),
      .den(m2_den_ff),
      .side_in(m2_side_ff),
      .out_valid(db_valid),
      .quo(db_quo),
      .side_out(db_side)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word = out_word_ff;

endmodule

[rtl/core/ccv_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, several lanes in
// step. The numerator must be below den * 2**QW so that the quotient fits.
module ccv_div #(
   parameter int LANES = 4,
   parameter int NW = 18,
   parameter int DW = 8,
   parameter int QW = 10,
   parameter int SW = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [LANES-1:0][NW-1:0] num,
   input  logic [LANES-1:0][DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic out_valid,
   output logic [LANES-1:0][QW-1:0] quo,
   output logic [SW-1:0] side_out
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic [LANES-1:0][RW-1:0] rem_ff [QW];
   logic [LANES-1:0][RW-1:0] rem_in [QW];
   logic [LANES-1:0][DW-1:0] den_ff [QW];
   logic [LANES-1:0][QW-1:0] quo_ff [QW];
   logic [LANES-1:0][QW-1:0] quo_in [QW];
   logic [SW-1:0] side_ff [QW];
   logic [QW-1:0] valid_ff;

   always_comb begin
      logic [RW-1:0] prev_rem;
      logic [DW-1:0] prev_den;
      logic [QW-1:0] prev_quo;
      logic [RW-1:0] trial;
      for (int s = 0; s < QW; s++) begin
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               prev_rem = RW'(num[l]);
               prev_den = den[l];
               prev_quo = '0;
            end else begin
               prev_rem = rem_ff[s-1][l];
               prev_den = den_ff[s-1][l];
               prev_quo = quo_ff[s-1][l];
            end
            trial = RW'(prev_den) << (QW - 1 - s);
            if (prev_rem >= trial) begin
               rem_in[s][l] = prev_rem - trial;
               quo_in[s][l] = prev_quo | (QW'(1) << (QW - 1 - s));
            end else begin
               rem_in[s][l] = prev_rem;
               quo_in[s][l] = prev_quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < QW; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            if (s == 0) begin
               den_ff[s] <= den;
               side_ff[s] <= side_in;
            end else begin
               den_ff[s] <= den_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quo = quo_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int LATENCY = 23;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam ccv_pkg::func_type FUNC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   ccv_pkg::level_type csr_write_data = '0;

   ccv_req_if req_chan ();
   ccv_rsp_if rsp_chan ();

   rgb_cmyk_color_convert u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   ccv_pkg::level_type levels_now = ccv_pkg::LEVELS_RESET;
   ccv_pkg::rsp_word_type pending_pixels[$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      rsp_chan.ready = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int unsigned to_rgb(input int unsigned comp, input int unsigned k,
                                          input int unsigned lv);
      longint unsigned num;
      num = 64'd255 * (lv - comp) * (lv - k);
      return 32'(num / (lv * lv));
   endfunction

   function automatic int unsigned clamp_level(input ccv_pkg::level_type v,
                                               input int unsigned lv);
      return (32'(v) > lv) ? lv : 32'(v);
   endfunction

   function automatic ccv_pkg::rsp_word_type convert_pixel(input ccv_pkg::req_word_type w);
      ccv_pkg::rsp_word_type o;
      int unsigned lv, mx, c, m, y, k;
      lv = (levels_now == 0) ? 1 : 32'(levels_now);
      o = '0;
      c = 0; m = 0; y = 0; k = 0;
      if (w.func == ccv_pkg::FUNC_TO_CMYK || w.func == ccv_pkg::FUNC_ROUND_TRIP) begin
         mx = 32'(w.red_in);
         if (32'(w.green_in) > mx) mx = 32'(w.green_in);
         if (32'(w.blue_in) > mx) mx = 32'(w.blue_in);
         k = ((255 - mx) * lv) / 255;
         if (mx != 0) begin
            c = ((mx - 32'(w.red_in)) * lv) / mx;
            m = ((mx - 32'(w.green_in)) * lv) / mx;
            y = ((mx - 32'(w.blue_in)) * lv) / mx;
         end
         o.cyan_out = ccv_pkg::level_type'(c);
         o.magenta_out = ccv_pkg::level_type'(m);
         o.yellow_out = ccv_pkg::level_type'(y);
         o.black_out = ccv_pkg::level_type'(k);
      end
      if (w.func == ccv_pkg::FUNC_TO_RGB) begin
         c = clamp_level(w.cyan_in, lv);
         m = clamp_level(w.magenta_in, lv);
         y = clamp_level(w.yellow_in, lv);
         k = clamp_level(w.black_in, lv);
      end
      if (w.func == ccv_pkg::FUNC_TO_RGB || w.func == ccv_pkg::FUNC_ROUND_TRIP) begin
         o.red_out = ccv_pkg::pixel_type'(to_rgb(c, k, lv));
         o.green_out = ccv_pkg::pixel_type'(to_rgb(m, k, lv));
         o.blue_out = ccv_pkg::pixel_type'(to_rgb(y, k, lv));
      end
      return o;
   endfunction

   // Receiver side: random stalls and a check of each word that is taken.
   always @(posedge clock) begin
      ccv_pkg::rsp_word_type want;
      ccv_pkg::rsp_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.word;
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (got.cyan_out != want.cyan_out)
               report_mismatch("cyan_out", int'(got.cyan_out), int'(want.cyan_out));
            if (got.magenta_out != want.magenta_out)
               report_mismatch("magenta_out", int'(got.magenta_out),
                               int'(want.magenta_out));
            if (got.yellow_out != want.yellow_out)
               report_mismatch("yellow_out", int'(got.yellow_out), int'(want.yellow_out));
            if (got.black_out != want.black_out)
               report_mismatch("black_out", int'(got.black_out), int'(want.black_out));
            if (got.red_out != want.red_out)
               report_mismatch("red_out", int'(got.red_out), int'(want.red_out));
            if (got.green_out != want.green_out)
               report_mismatch("green_out", int'(got.green_out), int'(want.green_out));
            if (got.blue_out != want.blue_out)
               report_mismatch("blue_out", int'(got.blue_out), int'(want.blue_out));
         end
      end
      rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Valid stays high from one word to the next; it drops only when the
   // sender idles or the stream is drained.
   task automatic send_pixel(input ccv_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_pixels.push_back(convert_pixel(w));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_levels(input ccv_pkg::level_type v);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      levels_now = v;
   endtask

   function automatic ccv_pkg::req_word_type make_word(input ccv_pkg::func_type f,
                                                       input int r, input int g,
                                                       input int b, input int c,
                                                       input int m, input int y,
                                                       input int k);
      ccv_pkg::req_word_type w;
      w.func = f;
      w.red_in = ccv_pkg::pixel_type'(r);
      w.green_in = ccv_pkg::pixel_type'(g);
      w.blue_in = ccv_pkg::pixel_type'(b);
      w.cyan_in = ccv_pkg::level_type'(c);
      w.magenta_in = ccv_pkg::level_type'(m);
      w.yellow_in = ccv_pkg::level_type'(y);
      w.black_in = ccv_pkg::level_type'(k);
      return w;
   endfunction

   function automatic ccv_pkg::req_word_type random_word();
      ccv_pkg::req_word_type w;
      w = ccv_pkg::req_word_type'({$urandom, $urandom, $urandom});
      // Mostly real functions; the unused code now and then.
      w.func = ($urandom_range(19) == 0) ? FUNC_UNUSED
                                         : ccv_pkg::func_type'($urandom_range(2));
      // CMYK inputs mostly in range, otherwise across the full width.
      if ($urandom_range(3) != 0) begin
         w.cyan_in = ccv_pkg::level_type'($urandom_range(1023) % (32'(levels_now) + 1));
         w.magenta_in = ccv_pkg::level_type'($urandom_range(1023) % (32'(levels_now) + 1));
         w.yellow_in = ccv_pkg::level_type'($urandom_range(1023) % (32'(levels_now) + 1));
         w.black_in = ccv_pkg::level_type'($urandom_range(1023) % (32'(levels_now) + 1));
      end
      if ($urandom_range(15) == 0) begin
         w.red_in = '0; w.green_in = '0; w.blue_in = '0;
      end
      return w;
   endfunction

   task automatic test_directed();
      send_pixel(make_word(ccv_pkg::FUNC_TO_CMYK, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_CMYK, 255, 255, 255, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_CMYK, 255, 0, 0, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_CMYK, 0, 1, 254, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_RGB, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_RGB, 0, 0, 0, 100, 100, 100, 100));
      send_pixel(make_word(ccv_pkg::FUNC_TO_RGB, 0, 0, 0, 1023, 101, 512, 0));
      send_pixel(make_word(ccv_pkg::FUNC_TO_RGB, 0, 0, 0, 0, 50, 99, 1023));
      send_pixel(make_word(ccv_pkg::FUNC_ROUND_TRIP, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_ROUND_TRIP, 255, 128, 1, 0, 0, 0, 0));
      send_pixel(make_word(ccv_pkg::FUNC_ROUND_TRIP, 255, 255, 255, 0, 0, 0, 0));
      send_pixel(make_word(FUNC_UNUSED, 255, 255, 255, 1023, 1023, 1023, 1023));
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (count) send_pixel(random_word());
   endtask

   task automatic test_levels_range();
      set_levels(10'd1023);
      test_directed();
      test_random(200, 0, 0);
      set_levels(10'd1);
      test_random(150, 9, 9);
      set_levels(10'd0);
      test_directed();
      test_random(150, 0, 78);
      set_levels(10'd255);
      test_random(200, 78, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 0, 0);
      test_random(150, 78, 0);
      test_random(150, 0, 78);
      test_random(100, 9, 9);
      test_levels_range();
      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/core/ccv_pkg.sv
rtl/core/ccv_req_if.sv
rtl/core/ccv_rsp_if.sv
rtl/core/ccv_div.sv
rtl/core/rgb_cmyk_color_convert.sv
tb/tb.sv
